[hw/rtl/lcdnw_pkg.sv]
// shared types, request codes and the init beat table for the lcd nibble writer
`timescale 1ns / 1ps
package lcdnw_pkg;

  localparam logic [1:0] REQ_STRING = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_INSTR  = 2'd2;
  localparam logic [1:0] REQ_INIT   = 2'd3;

  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] BYTE_LAST = 5'd3;
  localparam logic [STEP_W-1:0] WRAP_LAST = 5'd7;
  localparam logic [STEP_W-1:0] INIT_LAST = 5'd28;

  localparam logic [4:0] PULSE_MS = 5'd2;

  localparam logic [7:0] DDRAM_ROW1 = 8'h80;
  localparam logic [7:0] DDRAM_ROW2 = 8'hC0;

  typedef struct packed {
    logic              init;
    logic [7:0]        byte0;
    logic              rs0;
    logic [7:0]        byte1;
    logic [STEP_W-1:0] last_step;
  } job_t;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] last_step;
  } status_t;

  typedef struct packed {
    logic [7:0] port;
    logic [4:0] hold;
  } beat_t;

  // fixed power-up sequence, one port write per step
  function automatic beat_t init_beat(input logic [STEP_W-1:0] step);
    beat_t b;
    unique case (step)
      5'd0:  b = '{port: 8'h00, hold: 5'd20};
      5'd1:  b = '{port: 8'h34, hold: 5'd2};
      5'd2:  b = '{port: 8'h30, hold: 5'd7};
      5'd3:  b = '{port: 8'h34, hold: 5'd2};
      5'd4:  b = '{port: 8'h30, hold: 5'd3};
      5'd5:  b = '{port: 8'h34, hold: 5'd2};
      5'd6:  b = '{port: 8'h30, hold: 5'd3};
      5'd7:  b = '{port: 8'h24, hold: 5'd2};
      5'd8:  b = '{port: 8'h20, hold: 5'd2};
      // instruction 0x28
      5'd9:  b = '{port: 8'h24, hold: 5'd2};
      5'd10: b = '{port: 8'h20, hold: 5'd2};
      5'd11: b = '{port: 8'h84, hold: 5'd2};
      5'd12: b = '{port: 8'h80, hold: 5'd2};
      // instruction 0x80
      5'd13: b = '{port: 8'h84, hold: 5'd2};
      5'd14: b = '{port: 8'h80, hold: 5'd2};
      5'd15: b = '{port: 8'h04, hold: 5'd2};
      5'd16: b = '{port: 8'h00, hold: 5'd2};
      // instruction 0x01
      5'd17: b = '{port: 8'h04, hold: 5'd2};
      5'd18: b = '{port: 8'h00, hold: 5'd2};
      5'd19: b = '{port: 8'h14, hold: 5'd2};
      5'd20: b = '{port: 8'h10, hold: 5'd2};
      // instruction 0x06
      5'd21: b = '{port: 8'h04, hold: 5'd2};
      5'd22: b = '{port: 8'h00, hold: 5'd2};
      5'd23: b = '{port: 8'h64, hold: 5'd2};
      5'd24: b = '{port: 8'h60, hold: 5'd2};
      // instruction 0x0f
      5'd25: b = '{port: 8'h04, hold: 5'd2};
      5'd26: b = '{port: 8'h00, hold: 5'd2};
      5'd27: b = '{port: 8'hF4, hold: 5'd2};
      5'd28: b = '{port: 8'hF0, hold: 5'd2};
      default: b = '{port: 8'h00, hold: 5'd0};
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/lcdnw_req_if.sv]
// request channel: one beat per lcd request
`timescale 1ns / 1ps
interface lcdnw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_value;
  logic       string_start;

  modport source (output valid, req_type, char_value, string_start, input ready);
  modport sink (input valid, req_type, char_value, string_start, output ready);
endinterface

[hw/rtl/lcdnw_port_if.sv]
// port write channel: one beat per lcd port write
`timescale 1ns / 1ps
interface lcdnw_port_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_value;
  logic [4:0] wait_ms;
  logic       last;

  modport source (output valid, port_value, wait_ms, last, input ready);
  modport sink (input valid, port_value, wait_ms, last, output ready);
endinterface

[hw/rtl/lcdnw_plan.sv]
// turns one request into a job and keeps the string cursor state
`timescale 1ns / 1ps
module lcdnw_plan
  import lcdnw_pkg::*;
#(
  parameter int unsigned ROW_LENGTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] req_type,
  input  logic [7:0] char_value,
  input  logic       string_start,
  output job_t       job
);

  localparam int unsigned CNT_W = (ROW_LENGTH > 2) ? $clog2(ROW_LENGTH) : 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ROW_LENGTH - 1);

  logic [CNT_W-1:0] char_count;
  logic [CNT_W-1:0] char_count_next;
  logic             second_row;
  logic             second_row_next;

  logic [CNT_W-1:0] cnt_eff;
  logic             row_eff;
  logic             wrap;

  always_comb begin
    cnt_eff = string_start ? '0 : char_count;
    row_eff = string_start ? 1'b0 : second_row;
    wrap    = (cnt_eff >= CNT_END);

    char_count_next = char_count;
    second_row_next = second_row;
    if (req_type == REQ_STRING) begin
      char_count_next = wrap ? '0 : cnt_eff + CNT_W'(1);
      second_row_next = wrap ? ~row_eff : row_eff;
    end

    job.init      = (req_type == REQ_INIT);
    job.byte0     = char_value;
    job.rs0       = (req_type == REQ_STRING) || (req_type == REQ_DATA);
    job.byte1     = row_eff ? DDRAM_ROW1 : DDRAM_ROW2;
    job.last_step = BYTE_LAST;
    unique case (req_type)
      REQ_STRING: job.last_step = wrap ? WRAP_LAST : BYTE_LAST;
      REQ_INIT:   job.last_step = INIT_LAST;
      default:    job.last_step = BYTE_LAST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      second_row <= 1'b0;
    end else if (accept) begin
      char_count <= char_count_next;
      second_row <= second_row_next;
    end
  end

endmodule

[hw/rtl/lcdnw_seq.sv]
// job register, beat counter and output register for the port writes
`timescale 1ns / 1ps
module lcdnw_seq
  import lcdnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  job_t       job_in,
  output logic       can_load,
  output status_t    status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_port,
  output logic [4:0] out_wait,
  output logic       out_last
);

  job_t              job;
  logic              busy;
  logic [STEP_W-1:0] step;

  logic  issue;
  logic  at_last;
  beat_t beat;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] nib;

  always_comb begin
    issue    = busy && (!out_valid || out_ready);
    at_last  = (step == job.last_step);
    can_load = !busy || (issue && at_last);

    cur_byte = step[2] ? job.byte1 : job.byte0;
    cur_rs   = step[2] ? 1'b0 : job.rs0;
    nib      = step[1] ? cur_byte[3:0] : cur_byte[7:4];
    if (job.init) begin
      beat = init_beat(step);
    end else begin
      // enable high on even steps, low on odd
      beat.port = {nib, cur_rs, ~step[0], 2'b00};
      beat.hold = PULSE_MS;
    end

    status.busy      = busy;
    status.step      = step;
    status.last_step = job.last_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (issue) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_port <= beat.port;
      out_wait <= beat.hold;
      out_last <= at_last;
    end
  end

endmodule

[hw/rtl/char_lcd_nibble_writer.sv]
// top level of the 4-bit character lcd writer: requests in, port writes out
// usage:
//   req beats carry req_type, char_value and string_start; each request becomes
//   a run of lcd beats (port_value, wait_ms, last), one beat per port write
//   a string char or raw byte gives 4 beats, a string char that ends a row
//   gives 8 (the set-address instruction follows), init gives 29
//   a taken request is loaded into the job register, then its first lcd beat
//   moves into the output register, which gives one lcd beat per cycle while
//   the lcd sink is ready; the beat counter in the sequencer sets the pace
//   req ready rises again in the cycle the last beat of the running request
//   moves into the output register, so requests follow back to back
//   reset clears the row cursor (count 0, first row) and drops all beats
//   a stalled lcd sink freezes the output register and the beat counter;
//   no beat is dropped or repeated
`timescale 1ns / 1ps
module char_lcd_nibble_writer
  import lcdnw_pkg::*;
#(
  parameter int unsigned ROW_LENGTH = 16
) (
  input  logic clk,
  input  logic rst,
  lcdnw_req_if.sink    req,
  lcdnw_port_if.source lcd
);

  logic    accept;
  logic    can_load;
  job_t    job;
  status_t status;

  // request beat is taken when the sequencer is free or finishing
  assign req.ready = can_load;
  assign accept    = req.valid && can_load;

  // request decode and row cursor
  lcdnw_plan #(
    .ROW_LENGTH (ROW_LENGTH)
  ) u_plan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req.req_type),
    .char_value   (req.char_value),
    .string_start (req.string_start),
    .job          (job)
  );

  // beat generation and output register
  lcdnw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .job_in    (job),
    .can_load  (can_load),
    .status    (status),
    .out_valid (lcd.valid),
    .out_ready (lcd.ready),
    .out_port  (lcd.port_value),
    .out_wait  (lcd.wait_ms),
    .out_last  (lcd.last)
  );

  // after reset nothing is in flight
  a_reset_idle: assert property (@(posedge clk) rst |=> !status.busy && !lcd.valid)
    else $error("sequencer busy after reset");

  // beat counter never runs past the end of its job
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> status.step <= status.last_step)
    else $error("beat counter past last step");

  // a taken request starts at its first beat
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> status.busy && status.step == '0)
    else $error("request taken but job not started");

  // init always plays the full sequence
  a_init_len: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.req_type == REQ_INIT |=> status.last_step == INIT_LAST)
    else $error("init job has wrong length");

endmodule

[test/tb.sv]
// testbench for char_lcd_nibble_writer: random requests checked beat by beat against a predictor
`timescale 1ns / 1ps
module tb;
  import lcdnw_pkg::*;

  localparam int ROW_LEN = 16;
  // the slowest legal run stays well inside this limit, this leaves plenty of room
  localparam int CYCLE_LIMIT = 400000;
  // after the last expected beat, give the block time to show a stray one
  localparam int TAIL_CYCLES = 40;

  // port byte layout: nibble in 7..4, register select in 3, enable in 2
  localparam logic [7:0] EN_BIT = 8'h04;
  localparam logic [7:0] RS_BIT = 8'h08;

  // hd44780 instruction bytes used by the power-up sequence and row wrap
  localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
  localparam logic [7:0] LCD_SET_ADDR    = 8'h80;
  localparam logic [7:0] LCD_WIPE_SCREEN = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] LCD_SCREEN_ON   = 8'h0F;
  localparam logic [7:0] LCD_ROW1_ADDR   = 8'h00;
  localparam logic [7:0] LCD_ROW2_ADDR   = 8'h40;

  // raw nibbles of the reset and 4-bit switch steps
  localparam logic [7:0] WAKE_NIBBLE     = 8'h30;
  localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h20;
  localparam logic [4:0] POWER_UP_HOLD   = 5'd20;

  // one request as the sender sees it; pace picks how the sender idles after it
  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic       start;
    bit         drain;
    int         pace;
  } lcd_request_t;

  // one port write as the lcd side sees it
  typedef struct {
    logic [7:0] port;
    logic [4:0] hold;
    logic       last;
  } port_write_t;

  logic clk;
  logic rst;

  lcdnw_req_if  req_ch ();
  lcdnw_port_if lcd_ch ();

  char_lcd_nibble_writer #(
    .ROW_LENGTH(ROW_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .lcd(lcd_ch)
  );

  always #1 clk = ~clk;

  lcd_request_t req_backlog[$];
  lcd_request_t req_in_flight;
  port_write_t  expected_writes[$];
  port_write_t  want;

  // predictor copy of the row cursor
  int   row_pos;
  logic on_row2;

  int req_total;
  int reqs_accepted;
  int beats_seen;
  int mismatches;
  int send_gap;
  int sink_stall;
  int fill_pace;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // predictor: every accepted request appends its port writes to expected_writes
  // ---------------------------------------------------------------------------

  function automatic void push_port_write(input logic [7:0] port, input logic [4:0] hold);
    port_write_t w;
    w.port = port;
    w.hold = hold;
    w.last = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // one nibble strobe: enable high, then enable low with its own hold
  function automatic void push_nibble(input logic [7:0] base, input logic [4:0] low_hold);
    push_port_write(base | EN_BIT, PULSE_MS);
    push_port_write(base & ~EN_BIT, low_hold);
  endfunction

  // a full byte is the upper nibble and then the lower one, four beats
  function automatic void push_lcd_byte(input logic [7:0] b, input logic is_data);
    logic [7:0] rs;
    rs = is_data ? RS_BIT : 8'h00;
    push_nibble({b[7:4], 4'h0} | rs, PULSE_MS);
    push_nibble({b[3:0], 4'h0} | rs, PULSE_MS);
  endfunction

  function automatic void predict_request(input lcd_request_t r);
    port_write_t tail;
    case (r.kind)
      REQ_STRING: begin
        // string start clears the cursor before this char goes out
        if (r.start) begin
          row_pos = 0;
          on_row2 = 1'b0;
        end
        push_lcd_byte(r.value, 1'b1);
        // last column of a row: flip rows and move the lcd address there
        if (row_pos >= ROW_LEN - 1) begin
          row_pos = 0;
          on_row2 = ~on_row2;
          push_lcd_byte(LCD_SET_ADDR | (on_row2 ? LCD_ROW2_ADDR : LCD_ROW1_ADDR), 1'b0);
        end else begin
          row_pos++;
        end
      end
      REQ_DATA:  push_lcd_byte(r.value, 1'b1);
      REQ_INSTR: push_lcd_byte(r.value, 1'b0);
      default: begin
        // power-up sequence, cursor left alone; the set-address step is kept
        push_port_write(8'h00, POWER_UP_HOLD);
        push_nibble(WAKE_NIBBLE, 5'd7);
        push_nibble(WAKE_NIBBLE, 5'd3);
        push_nibble(WAKE_NIBBLE, 5'd3);
        push_nibble(FOUR_BIT_NIBBLE, PULSE_MS);
        push_lcd_byte(LCD_FUNC_SET, 1'b0);
        push_lcd_byte(LCD_SET_ADDR, 1'b0);
        push_lcd_byte(LCD_WIPE_SCREEN, 1'b0);
        push_lcd_byte(LCD_ENTRY_MODE, 1'b0);
        push_lcd_byte(LCD_SCREEN_ON, 1'b0);
      end
    endcase
    // the final beat of every request carries last
    tail = expected_writes.pop_back();
    tail.last = 1'b1;
    expected_writes.push_back(tail);
  endfunction

  // idle draw per item: pace 0 never idles, 1 idles 0..15, 2 idles now and then
  function automatic int draw_idle(input int pace);
    case (pace)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic void add_request(input logic [1:0] kind, input logic [7:0] value,
                                      input logic start, input bit drain);
    lcd_request_t r;
    r.kind  = kind;
    r.value = value;
    r.start = start;
    r.drain = drain;
    r.pace  = fill_pace;
    req_backlog.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: launches backlog items, predicts on each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_STRING;
      req_ch.char_value   <= 8'h00;
      req_ch.string_start <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_request(req_in_flight);
        reqs_accepted++;
      end
      // the channel is free when nothing is offered or the offer was just taken
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() > 0 &&
                     !(req_backlog[0].drain && expected_writes.size() != 0)) begin
          // a drain item holds back until every beat owed so far has arrived
          req_in_flight = req_backlog.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.req_type     <= req_in_flight.kind;
          req_ch.char_value   <= req_in_flight.value;
          req_ch.string_start <= req_in_flight.start;
          send_gap = draw_idle(req_in_flight.pace);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // lcd monitor: random back-pressure, each beat checked against the oldest
  // expected port write
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      lcd_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (lcd_ch.valid && lcd_ch.ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: lcd beat with nothing expected: port_value %02h wait_ms %0d last %0b",
                   $time, lcd_ch.port_value, lcd_ch.wait_ms, lcd_ch.last);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          if (lcd_ch.port_value !== want.port) begin
            $display("%0t: beat %0d port_value expected %02h actual %02h",
                     $time, beats_seen, want.port, lcd_ch.port_value);
            mismatches++;
          end
          if (lcd_ch.wait_ms !== want.hold) begin
            $display("%0t: beat %0d wait_ms expected %0d actual %0d",
                     $time, beats_seen, want.hold, lcd_ch.wait_ms);
            mismatches++;
          end
          if (lcd_ch.last !== want.last) begin
            $display("%0t: beat %0d last expected %0b actual %0b",
                     $time, beats_seen, want.last, lcd_ch.last);
            mismatches++;
          end
        end
        beats_seen++;
        // stall pattern shifts every few dozen beats, with calm stretches between
        sink_stall = draw_idle((beats_seen / 48) % 3);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        lcd_ch.ready <= 1'b0;
      end else begin
        lcd_ch.ready <= 1'b1;
      end
    end
  end

  // run guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("char_lcd_nibble_writer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int random_count;
    int roll;
    int str_len;

    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_STRING;
    req_ch.char_value   = 8'h00;
    req_ch.string_start = 1'b0;
    lcd_ch.ready        = 1'b0;
    row_pos       = 0;
    on_row2       = 1'b0;
    reqs_accepted = 0;
    beats_seen    = 0;
    mismatches    = 0;
    fill_pace     = 0;

    // directed part, back to back: power-up, byte extremes, string start on
    // requests that ignore it, then a full row that wraps onto the second row
    add_request(REQ_INIT, 8'h00, 1'b0, 1'b0);
    add_request(REQ_INSTR, 8'h00, 1'b1, 1'b0);
    add_request(REQ_INSTR, 8'hFF, 1'b0, 1'b0);
    add_request(REQ_DATA, 8'h00, 1'b0, 1'b0);
    add_request(REQ_DATA, 8'hFF, 1'b1, 1'b0);
    add_request(REQ_STRING, 8'h41, 1'b1, 1'b0);
    for (int i = 1; i < ROW_LEN; i++) begin
      add_request(REQ_STRING,
                  (i == 7) ? 8'h00 : ((i == 8) ? 8'hFF : 8'(8'h41 + i)), 1'b0, 1'b0);
    end
    // carries on in the second row, then a fresh string mid-row
    add_request(REQ_STRING, 8'h5A, 1'b0, 1'b0);
    add_request(REQ_STRING, 8'hA5, 1'b1, 1'b0);
    // init after a full drain, then the cursor must be where the string left it
    add_request(REQ_INIT, 8'hFF, 1'b1, 1'b1);
    add_request(REQ_STRING, 8'h3C, 1'b0, 1'b0);

    // random part: mostly well-formed strings, some long enough to wrap twice,
    // mixed with raw bytes, instructions, inits and stray string chars
    random_count = 0;
    while (random_count < 70) begin
      fill_pace = (random_count / 16) % 3;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        str_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        for (int i = 0; i < str_len; i++) begin
          add_request(REQ_STRING, 8'($urandom_range(0, 255)), i == 0,
                      $urandom_range(0, 24) == 0);
        end
        random_count += str_len;
      end else begin
        if (roll < 70) begin
          add_request(REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end else if (roll < 85) begin
          add_request(REQ_INSTR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end else if (roll < 90) begin
          add_request(REQ_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
          // string char that may or may not restart the cursor
          add_request(REQ_STRING, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0);
        end
        random_count++;
      end
    end
    req_total = req_backlog.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sample on the falling edge so the counters are settled
    @(negedge clk);
    while (reqs_accepted < req_total || expected_writes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("char_lcd_nibble_writer: match");
    end else begin
      $display("char_lcd_nibble_writer: mismatch");
    end
    $finish;
  end

endmodule
